FILE: hdl/tccu_pkg.sv
// ----------------------------------------------------------------------------
// tccu_pkg: shared types and constants of the text console cursor engine
// Character codes, register indexes, configuration and job records.
// ----------------------------------------------------------------------------
package tccu_pkg;

  // Control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Tab stop spacing, a power of two
  localparam int unsigned TAB_STEP = 4;

  // Register indexes on the configuration port
  localparam int unsigned   CFG_IDX_W       = 3;
  localparam logic [2:0]    REG_COLUMNS     = 3'd0;
  localparam logic [2:0]    REG_ROWS        = 3'd1;
  localparam logic [2:0]    REG_CELL_WIDTH  = 3'd2;
  localparam logic [2:0]    REG_CELL_HEIGHT = 3'd3;
  localparam logic [2:0]    REG_LEFT_PAD    = 3'd4;
  localparam logic [2:0]    REG_TOP_PAD     = 3'd5;
  localparam logic [2:0]    REG_LINE_STRIDE = 3'd6;
  localparam logic [2:0]    REG_BPP         = 3'd7;
  localparam int unsigned   CFG_DATA_W      = 16;

  // Saturation limits
  localparam logic [13:0] PIX_MAX = 14'h3FFF;
  localparam logic [29:0] OFF_MAX = 30'h3FFF_FFFF;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  rows;
    logic [5:0]  cell_width;
    logic [5:0]  cell_height;
    logic [11:0] left_pad;
    logic [11:0] top_pad;
    logic [15:0] line_stride;
    logic [2:0]  bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic       print;      // printable byte: report the cell position
    logic       glyph;
    logic [7:0] col;        // cursor before the step
    logic [7:0] row;
    logic [7:0] col_after;
    logic [7:0] row_after;
    logic       last;
  } job_t;

endpackage

FILE: hdl/text_console_cursor_engine.sv
// Text console cursor engine, top level.
// Each job passes the job queue and then stage 1, stage 2 and the result register.
// Throughput: one character per cycle; the back pipeline stalls as a whole on
// output backpressure; a 4-entry job queue lets the front accept until it is full.
// Reset: rst_ni clears the cursor to the origin, empties queue and pipeline,
// and loads the register defaults (80 x 25 cells of 8 x 16, stride 2560, 4 B/px).
// ----------------------------------------------------------------------------
// text_console_cursor_engine: character stream to cursor and cell addresses
// Holds the configuration registers and joins front, job queue and back end.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tccu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tuser,   // [0] glyph_present
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [13:0] pixel_x, [27:14] pixel_y, [57:28] fb_offset,
  // [65:58] col_after, [73:66] row_after, [79:74] zero
  output logic [79:0]           m_axis_tdata,
  output logic                  m_axis_tuser,   // [0] draw
  output logic                  m_axis_tlast
);

  cfg_t        cfg_q;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  job_t        job_in;
  job_t        job_out;
  logic [13:0] pixel_x;
  logic [13:0] pixel_y;
  logic [29:0] fb_offset;
  logic [7:0]  col_after;
  logic [7:0]  row_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns         <= 8'd80;
      cfg_q.rows            <= 8'd25;
      cfg_q.cell_width      <= 6'd8;
      cfg_q.cell_height     <= 6'd16;
      cfg_q.left_pad        <= 12'd0;
      cfg_q.top_pad         <= 12'd0;
      cfg_q.line_stride     <= 16'd2560;
      cfg_q.bytes_per_pixel <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLUMNS:     cfg_q.columns         <= cfg_data_i[7:0];
        REG_ROWS:        cfg_q.rows            <= cfg_data_i[7:0];
        REG_CELL_WIDTH:  cfg_q.cell_width      <= cfg_data_i[5:0];
        REG_CELL_HEIGHT: cfg_q.cell_height     <= cfg_data_i[5:0];
        REG_LEFT_PAD:    cfg_q.left_pad        <= cfg_data_i[11:0];
        REG_TOP_PAD:     cfg_q.top_pad         <= cfg_data_i[11:0];
        REG_LINE_STRIDE: cfg_q.line_stride     <= cfg_data_i;
        REG_BPP:         cfg_q.bytes_per_pixel <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  tccu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .char_code_i     (s_axis_tdata),
    .glyph_present_i (s_axis_tuser),
    .last_char_i     (s_axis_tlast),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (job_in)
  );

  tccu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (queue_full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (queue_empty)
  );

  tccu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (!queue_empty),
    .job_i          (job_out),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .draw_o         (m_axis_tuser),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .fb_offset_o    (fb_offset),
    .col_after_o    (col_after),
    .row_after_o    (row_after),
    .end_of_write_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, row_after, col_after, fb_offset, pixel_y, pixel_x};

endmodule

FILE: hdl/tccu_fifo.sv
// ----------------------------------------------------------------------------
// tccu_fifo: job queue
// Short register queue that decouples the cursor front from the address back.
// ----------------------------------------------------------------------------
module tccu_fifo
  import tccu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue read while empty");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])
    else $error("job queue pointers disagree with fill count");
`endif

endmodule

FILE: hdl/tccu_front.sv
// ----------------------------------------------------------------------------
// tccu_front: character front end
// Accepts characters, decodes control codes and updates the text cursor.
// ----------------------------------------------------------------------------
module tccu_front
  import tccu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_code_i,
  input  logic       glyph_present_i,
  input  logic       last_char_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic       enabled;
  logic       print;
  logic [8:0] col_inc;
  logic [8:0] row_inc;
  logic [8:0] tab_col;
  logic [7:0] row_next;

  assign ready_o = !queue_full_i;
  assign push_o  = valid_i && ready_o;
  assign enabled = (cfg_i.columns != '0) && (cfg_i.rows != '0);

  always_comb begin
    col_inc  = {1'b0, col_q} + 9'd1;
    row_inc  = {1'b0, row_q} + 9'd1;
    row_next = (row_inc >= {1'b0, cfg_i.rows}) ? 8'd0 : row_inc[7:0];
    // advance to the next tab stop after the current column
    tab_col  = ({1'b0, col_q} + 9'(TAB_STEP)) & ~9'(TAB_STEP - 1);
    col_d    = col_q;
    row_d    = row_q;
    print    = 1'b0;
    if (enabled) begin
      case (char_code_i)
        CH_BS: begin
          if (col_q != '0) begin
            col_d = col_q - 8'd1;
          end else if (row_q != '0) begin
            col_d = cfg_i.columns - 8'd1;
            row_d = row_q - 8'd1;
          end
        end
        CH_TAB: begin
          if (tab_col < {1'b0, cfg_i.columns}) begin
            col_d = tab_col[7:0];
          end
        end
        CH_CR: begin
          col_d = '0;
        end
        CH_LF: begin
          col_d = '0;
          row_d = row_next;
        end
        default: begin
          print = 1'b1;
          if (col_inc >= {1'b0, cfg_i.columns}) begin
            col_d = '0;
            row_d = row_next;
          end else begin
            col_d = col_inc[7:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    job_o.print     = print;
    job_o.glyph     = glyph_present_i;
    job_o.col       = col_q;
    job_o.row       = row_q;
    job_o.col_after = col_d;
    job_o.row_after = row_d;
    job_o.last      = last_char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hdl/tccu_back.sv
// ----------------------------------------------------------------------------
// tccu_back: cell address back end
// Three-stage pipeline: pixel origin, products, offset sum and saturation.
// ----------------------------------------------------------------------------
module tccu_back
  import tccu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic        draw_o,
  output logic [13:0] pixel_x_o,
  output logic [13:0] pixel_y_o,
  output logic [29:0] fb_offset_o,
  output logic [7:0]  col_after_o,
  output logic [7:0]  row_after_o,
  output logic        end_of_write_o
);

  logic        advance;

  // stage 1: pixel origin
  logic        s1_valid_q;
  job_t        s1_job_q;
  logic [14:0] s1_x_q, s1_x_d;
  logic [14:0] s1_y_q, s1_y_d;

  // stage 2: offset products
  logic        s2_valid_q;
  job_t        s2_job_q;
  logic [13:0] s2_px_q;
  logic [13:0] s2_py_q;
  logic [30:0] s2_row_off_q;
  logic [17:0] s2_col_off_q;

  // stage 3: result register
  logic        out_valid_q;
  logic [31:0] off_sum;
  logic [29:0] off_sat;

  assign advance = !out_valid_q || m_ready_i;
  assign pop_o   = advance && job_valid_i;

  always_comb begin
    s1_x_d  = 15'(job_i.col * cfg_i.cell_width) + 15'(cfg_i.left_pad);
    s1_y_d  = 15'(job_i.row * cfg_i.cell_height) + 15'(cfg_i.top_pad);
    off_sum = 32'(s2_row_off_q) + 32'(s2_col_off_q);
    off_sat = (off_sum > 32'(OFF_MAX)) ? OFF_MAX : off_sum[29:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= job_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_job_q     <= job_i;
      s1_x_q       <= s1_x_d;
      s1_y_q       <= s1_y_d;
      s2_job_q     <= s1_job_q;
      s2_px_q      <= (s1_x_q > 15'(PIX_MAX)) ? PIX_MAX : s1_x_q[13:0];
      s2_py_q      <= (s1_y_q > 15'(PIX_MAX)) ? PIX_MAX : s1_y_q[13:0];
      s2_row_off_q <= s1_y_q * cfg_i.line_stride;
      s2_col_off_q <= s1_x_q * cfg_i.bytes_per_pixel;
      // control codes report a zero position
      draw_o         <= s2_job_q.print & s2_job_q.glyph;
      pixel_x_o      <= s2_job_q.print ? s2_px_q : '0;
      pixel_y_o      <= s2_job_q.print ? s2_py_q : '0;
      fb_offset_o    <= s2_job_q.print ? off_sat : '0;
      col_after_o    <= s2_job_q.col_after;
      row_after_o    <= s2_job_q.row_after;
      end_of_write_o <= s2_job_q.last;
    end
  end

  assign m_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_hold_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("stage 1 item lost during stall");

  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> s1_valid_q)
    else $error("popped job did not enter stage 1");

  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |-> !pop_o)
    else $error("job popped while result stalled");
`endif

endmodule
